@@ hw/rtl/dssa_pkg.sv @@
`timescale 1ns / 1ps

package dssa_pkg;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_SESSION,
        CMD_SECURITY
    } cmd_kind_t;

    typedef enum logic [1:0] {
        CFG_SEED     = 2'd0,
        CFG_LOCKOUT  = 2'd1,
        CFG_MAX_FAIL = 2'd2
    } cfg_index_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // classified word passed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  sf;
        logic [15:0] rkey;
        logic        len_two;
        logic        len_four;
        logic        busy;
    } cmd_t;

    typedef struct packed {
        logic [2:0] resp_len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       unlocked;
    } res_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef struct packed {
        logic unlocked;
        logic awaiting;
        logic seed_nz;
        logic running;
        logic pending;
    } back_stat_t;

    localparam logic [7:0]  SID_SESSION  = 8'h10;
    localparam logic [7:0]  SID_SECURITY = 8'h27;
    localparam logic [7:0]  NEG_SID      = 8'h7F;
    localparam logic [7:0]  POS_OFFSET   = 8'h40;
    localparam logic [15:0] KEY_MASK     = 16'h1234;

    localparam logic [7:0] NRC_NONE     = 8'h00;
    localparam logic [7:0] NRC_SFNS     = 8'h12;
    localparam logic [7:0] NRC_LEN      = 8'h13;
    localparam logic [7:0] NRC_COND     = 8'h22;
    localparam logic [7:0] NRC_SEQ      = 8'h24;
    localparam logic [7:0] NRC_KEY      = 8'h35;
    localparam logic [7:0] NRC_ATTEMPTS = 8'h36;
    localparam logic [7:0] NRC_DELAY    = 8'h37;
    localparam logic [7:0] NRC_UNKNOWN  = 8'hFF;

    localparam logic [15:0] SEED_RESET     = 16'd123;
    localparam logic [15:0] LOCKOUT_RESET  = 16'd1000;
    localparam logic [3:0]  MAX_FAIL_RESET = 4'd3;

    localparam logic [2:0] LEN_NEG   = 3'd3;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_SEED  = 3'd4;

    localparam logic [7:0]  SF_SEED     = 8'd1;
    localparam logic [7:0]  SF_KEY      = 8'd2;
    localparam logic [7:0]  SESSION_MAX = 8'd3;
    localparam logic [11:0] PDU_SHORT   = 12'd2;
    localparam logic [11:0] PDU_KEY     = 12'd4;

endpackage

@@ hw/rtl/dssa_fifo.sv @@
`timescale 1ns / 1ps

module dssa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/dssa_front.sv @@
`timescale 1ns / 1ps

module dssa_front
    import dssa_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  sid,
    input  logic [7:0]  sub_function,
    input  logic [7:0]  key_high,
    input  logic [7:0]  key_low,
    input  logic [11:0] pdu_length,
    input  logic        loader_busy,
    input  logic        cmd_pop,
    output logic        cmd_empty,
    output cmd_t        cmd
);

    cmd_t             cmd_in;
    logic             keep;
    logic [$bits(cmd_t)-1:0] cmd_raw;

    // unknown services are accepted and dropped here
    always_comb
    begin
        cmd_in.sf       = sub_function;
        cmd_in.rkey     = {key_high, key_low};
        cmd_in.len_two  = (pdu_length == PDU_SHORT);
        cmd_in.len_four = (pdu_length == PDU_KEY);
        cmd_in.busy     = loader_busy;
        keep            = 1'b1;
        if (req_type)
        begin
            cmd_in.kind = CMD_TICK;
        end
        else if (sid == SID_SESSION)
        begin
            cmd_in.kind = CMD_SESSION;
        end
        else if (sid == SID_SECURITY)
        begin
            cmd_in.kind = CMD_SECURITY;
        end
        else
        begin
            cmd_in.kind = CMD_TICK;
            keep        = 1'b0;
        end
    end

    dssa_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_raw),
        .full    (full),
        .empty   (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_raw);

endmodule

@@ hw/rtl/dssa_back.sv @@
`timescale 1ns / 1ps

module dssa_back
    import dssa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_wr_t    cfg_wr,
    input  logic       cmd_empty,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic       res_full,
    output logic       res_push,
    output res_t       res,
    output back_stat_t stat
);

    logic [15:0] seed_value_reg;
    logic [15:0] lockout_ticks_reg;
    logic [3:0]  max_fail_reg;

    logic [1:0]  session_mode_reg;
    logic [1:0]  session_mode_next;
    logic        unlocked_reg;
    logic        unlocked_next;
    logic        awaiting_reg;
    logic        awaiting_next;
    logic [15:0] stored_seed_reg;
    logic [15:0] stored_seed_next;
    logic [3:0]  failed_count_reg;
    logic [3:0]  failed_count_next;
    logic        running_reg;
    logic        running_next;
    logic        pending_reg;
    logic        pending_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;

    logic        go;
    logic [7:0]  nrc;
    logic [7:0]  sid_echo;
    logic [2:0]  plen;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [15:0] expect_key;
    logic [3:0]  fc_adj;
    logic [3:0]  fc_inc;

    assign go       = !cmd_empty && (!res_full || (cmd.kind == CMD_TICK));
    assign cmd_pop  = go;
    assign res_push = go && (cmd.kind != CMD_TICK);

    always_comb
    begin
        session_mode_next = session_mode_reg;
        unlocked_next     = unlocked_reg;
        awaiting_next     = awaiting_reg;
        stored_seed_next  = stored_seed_reg;
        failed_count_next = failed_count_reg;
        running_next      = running_reg;
        pending_next      = pending_reg;
        remaining_next    = remaining_reg;
        nrc               = NRC_NONE;
        plen              = LEN_SHORT;
        b2                = '0;
        b3                = '0;
        sid_echo          = SID_SESSION;
        expect_key        = (stored_seed_reg != '0) ? (stored_seed_reg | KEY_MASK) : '0;
        fc_adj            = (failed_count_reg >= max_fail_reg) ? failed_count_reg - 1'b1
                                                               : failed_count_reg;
        fc_inc            = fc_adj + 1'b1;

        unique case (cmd.kind)
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    if (remaining_reg != '0)
                    begin
                        pending_next   = 1'b1;
                        remaining_next = remaining_reg - 1'b1;
                    end
                    else
                    begin
                        running_next   = 1'b0;
                        pending_next   = 1'b0;
                        remaining_next = '0;
                    end
                end
            end
            CMD_SESSION:
            begin
                sid_echo = SID_SESSION;
                if (cmd.sf > SESSION_MAX)
                begin
                    nrc = NRC_SFNS;
                end
                else if (!cmd.len_two)
                begin
                    nrc = NRC_LEN;
                end
                else if (cmd.busy)
                begin
                    nrc = NRC_COND;
                end
                else
                begin
                    session_mode_next = cmd.sf[1:0];
                end
            end
            CMD_SECURITY:
            begin
                sid_echo = SID_SECURITY;
                if (pending_reg)
                begin
                    nrc = NRC_DELAY;
                end
                else if (unlocked_reg)
                begin
                    nrc = NRC_COND;
                end
                else
                begin
                    running_next   = 1'b0;
                    pending_next   = 1'b0;
                    remaining_next = '0;
                    if (!awaiting_reg)
                    begin
                        if (cmd.sf == SF_KEY)
                        begin
                            nrc = NRC_SEQ;
                        end
                        else if (cmd.sf != SF_SEED)
                        begin
                            nrc = NRC_SFNS;
                        end
                        else if (!cmd.len_two)
                        begin
                            nrc = NRC_LEN;
                        end
                        else if (cmd.busy)
                        begin
                            nrc = NRC_COND;
                        end
                        else
                        begin
                            stored_seed_next = seed_value_reg;
                            if (seed_value_reg == '0)
                            begin
                                nrc = NRC_UNKNOWN;
                            end
                            else
                            begin
                                plen          = LEN_SEED;
                                b2            = seed_value_reg[15:8];
                                b3            = seed_value_reg[7:0];
                                awaiting_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // any key-phase outcome drops back to the seed phase
                        awaiting_next = 1'b0;
                        if (cmd.sf == SF_SEED)
                        begin
                            nrc = NRC_SEQ;
                        end
                        else if (cmd.sf != SF_KEY)
                        begin
                            nrc = NRC_SFNS;
                        end
                        else if (!cmd.len_four)
                        begin
                            nrc = NRC_LEN;
                        end
                        else if (cmd.busy)
                        begin
                            nrc = NRC_COND;
                        end
                        else
                        begin
                            stored_seed_next = '0;
                            if (cmd.rkey == expect_key)
                            begin
                                unlocked_next     = 1'b1;
                                failed_count_next = '0;
                            end
                            else
                            begin
                                failed_count_next = fc_inc;
                                if (fc_inc >= max_fail_reg)
                                begin
                                    remaining_next = lockout_ticks_reg;
                                    pending_next   = 1'b1;
                                    running_next   = 1'b1;
                                    nrc            = NRC_ATTEMPTS;
                                end
                                else
                                begin
                                    nrc = NRC_KEY;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                nrc = NRC_NONE;
            end
        endcase

        if (nrc != NRC_NONE)
        begin
            res.resp_len = LEN_NEG;
            res.b0       = NEG_SID;
            res.b1       = sid_echo;
            res.b2       = nrc;
            res.b3       = '0;
        end
        else
        begin
            res.resp_len = plen;
            res.b0       = sid_echo + POS_OFFSET;
            res.b1       = cmd.sf;
            res.b2       = b2;
            res.b3       = b3;
        end
        res.unlocked = unlocked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg    <= SEED_RESET;
            lockout_ticks_reg <= LOCKOUT_RESET;
            max_fail_reg      <= MAX_FAIL_RESET;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                CFG_SEED:     seed_value_reg    <= cfg_wr.data;
                CFG_LOCKOUT:  lockout_ticks_reg <= cfg_wr.data;
                CFG_MAX_FAIL: max_fail_reg      <= cfg_wr.data[3:0];
                default:      max_fail_reg      <= max_fail_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_mode_reg <= '0;
            unlocked_reg     <= 1'b0;
            awaiting_reg     <= 1'b0;
            stored_seed_reg  <= '0;
            failed_count_reg <= '0;
            running_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            remaining_reg    <= '0;
        end
        else if (go)
        begin
            session_mode_reg <= session_mode_next;
            unlocked_reg     <= unlocked_next;
            awaiting_reg     <= awaiting_next;
            stored_seed_reg  <= stored_seed_next;
            failed_count_reg <= failed_count_next;
            running_reg      <= running_next;
            pending_reg      <= pending_next;
            remaining_reg    <= remaining_next;
        end
    end

    assign stat.unlocked = unlocked_reg;
    assign stat.awaiting = awaiting_reg;
    assign stat.seed_nz  = (stored_seed_reg != '0);
    assign stat.running  = running_reg;
    assign stat.pending  = pending_reg;

endmodule

@@ hw/rtl/diag_session_security_access.sv @@
`timescale 1ns / 1ps
// path: a request is written into the command queue, then the back end pops it and writes its
// response into the response queue; non-tick words stall while that queue is full
// throughput: one word per cycle in and out unless stalled; all service state moves on each pop
// ticks and unknown services give no response; unknown services are dropped at the front
// reset: asynchronous, clears both queues and all service state, loads register defaults
// (seed 123, lockout 1000 ticks, 3 failed attempts); no clearing pass

module diag_session_security_access
    import dssa_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   req_type,
    input  logic [7:0]             sid,
    input  logic [7:0]             sub_function,
    input  logic [7:0]             key_high,
    input  logic [7:0]             key_low,
    input  logic [11:0]            pdu_length,
    input  logic                   loader_busy,
    output logic                   empty,
    input  logic                   pop,
    output logic [2:0]             resp_len,
    output logic [7:0]             resp_byte0,
    output logic [7:0]             resp_byte1,
    output logic [7:0]             resp_byte2,
    output logic [7:0]             resp_byte3,
    output logic                   unlocked,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t       cmd;
    logic       cmd_empty;
    logic       cmd_pop;
    res_t       res_in;
    res_t       res_out;
    logic       res_push;
    logic       res_full;
    cfg_wr_t    cfg_wr;
    back_stat_t stat;
    logic [$bits(res_t)-1:0] res_raw;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    dssa_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .sid          (sid),
        .sub_function (sub_function),
        .key_high     (key_high),
        .key_low      (key_low),
        .pdu_length   (pdu_length),
        .loader_busy  (loader_busy),
        .cmd_pop      (cmd_pop),
        .cmd_empty    (cmd_empty),
        .cmd          (cmd)
    );

    dssa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .stat      (stat)
    );

    dssa_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_raw),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_out    = res_t'(res_raw);
    assign resp_len   = res_out.resp_len;
    assign resp_byte0 = res_out.b0;
    assign resp_byte1 = res_out.b1;
    assign resp_byte2 = res_out.b2;
    assign resp_byte3 = res_out.b3;
    assign unlocked   = res_out.unlocked;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("response written into a full queue");

    a_unlock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(stat.unlocked))
        else $error("security level dropped");

    a_pending_needs_timer: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pending |-> stat.running)
        else $error("lockout pending without running timer");

    a_key_phase_has_seed: assert property (@(posedge clk) disable iff (!rst_n)
        stat.awaiting |-> stat.seed_nz)
        else $error("key phase entered without a stored seed");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dssa_pkg::*;

    localparam logic REQ_DIAG = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 90;
    localparam int LIMIT = 5000000;

    typedef struct packed {
        logic        is_tick;
        logic [7:0]  sid;
        logic [7:0]  sf;
        logic [7:0]  key_hi;
        logic [7:0]  key_lo;
        logic [11:0] pdu;
        logic        busy;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic req_type = REQ_DIAG;
    logic [7:0] sid = '0;
    logic [7:0] sub_function = '0;
    logic [7:0] key_high = '0;
    logic [7:0] key_low = '0;
    logic [11:0] pdu_length = '0;
    logic loader_busy = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [2:0] resp_len;
    logic [7:0] resp_byte0;
    logic [7:0] resp_byte1;
    logic [7:0] resp_byte2;
    logic [7:0] resp_byte3;
    logic unlocked;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copies
    logic [15:0] seed_reg = SEED_RESET;
    logic [15:0] lockout_reg = LOCKOUT_RESET;
    logic [3:0] max_fail_reg = MAX_FAIL_RESET;

    // service state copies
    logic [1:0] session_mode = '0;
    logic sec_open = 1'b0;
    logic want_key = 1'b0;
    logic [15:0] seed_held = '0;
    logic [3:0] fail_cnt = '0;
    logic lock_run = 1'b0;
    logic lock_hold = 1'b0;
    logic [15:0] lock_left = '0;

    word_t pending_words[$];
    res_t due_responses[$];
    int mismatches = 0;
    int made = 0;
    int cycles = 0;
    logic word_taken = 1'b0;
    logic hold_arm = 1'b0;
    logic hold_long = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int stall_tick = 0;

    always #2 clk = ~clk;

    diag_session_security_access uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req_type(req_type),
        .sid(sid),
        .sub_function(sub_function),
        .key_high(key_high),
        .key_low(key_low),
        .pdu_length(pdu_length),
        .loader_busy(loader_busy),
        .empty(empty),
        .pop(pop),
        .resp_len(resp_len),
        .resp_byte0(resp_byte0),
        .resp_byte1(resp_byte1),
        .resp_byte2(resp_byte2),
        .resp_byte3(resp_byte3),
        .unlocked(unlocked),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic void stop_lock();
        lock_run = 1'b0;
        lock_hold = 1'b0;
        lock_left = '0;
    endfunction

    function automatic logic [7:0] security_answer(input word_t w, output logic [2:0] plen,
                                                   output logic [7:0] b2,
                                                   output logic [7:0] b3);
        logic [15:0] want;
        plen = LEN_SHORT;
        b2 = '0;
        b3 = '0;
        if (lock_hold)
            return NRC_DELAY;
        if (sec_open)
            return NRC_COND;
        stop_lock();
        if (!want_key)
        begin
            if (w.sf == SF_KEY)
                return NRC_SEQ;
            if (w.sf != SF_SEED)
                return NRC_SFNS;
            if (w.pdu != PDU_SHORT)
                return NRC_LEN;
            if (w.busy)
                return NRC_COND;
            seed_held = seed_reg;
            if (seed_held == 16'd0)
                return NRC_UNKNOWN;
            plen = LEN_SEED;
            b2 = seed_held[15:8];
            b3 = seed_held[7:0];
            want_key = 1'b1;
            return NRC_NONE;
        end
        // any key-phase request drops back to the seed phase
        want_key = 1'b0;
        if (w.sf == SF_SEED)
            return NRC_SEQ;
        if (w.sf != SF_KEY)
            return NRC_SFNS;
        if (w.pdu != PDU_KEY)
            return NRC_LEN;
        if (w.busy)
            return NRC_COND;
        want = '0;
        if (seed_held != 16'd0)
        begin
            want = seed_held | KEY_MASK;
            seed_held = '0;
        end
        if (fail_cnt >= max_fail_reg)
            fail_cnt = fail_cnt - 4'd1;
        if ({w.key_hi, w.key_lo} == want)
        begin
            sec_open = 1'b1;
            fail_cnt = '0;
            return NRC_NONE;
        end
        fail_cnt = fail_cnt + 4'd1;
        if (fail_cnt >= max_fail_reg)
        begin
            lock_left = lockout_reg;
            lock_hold = 1'b1;
            lock_run = 1'b1;
            return NRC_ATTEMPTS;
        end
        return NRC_KEY;
    endfunction

    // updates the service state, returns 1 when the word yields a response
    function automatic bit serve_word(input word_t w, output res_t r);
        logic [7:0] nrc;
        logic [2:0] plen;
        logic [7:0] b2;
        logic [7:0] b3;
        r = '0;
        plen = LEN_SHORT;
        b2 = '0;
        b3 = '0;
        nrc = NRC_NONE;
        if (w.is_tick == REQ_TICK)
        begin
            if (lock_run)
            begin
                if (lock_left != 16'd0)
                begin
                    lock_hold = 1'b1;
                    lock_left = lock_left - 16'd1;
                end
                else
                    stop_lock();
            end
            return 1'b0;
        end
        if (w.sid == SID_SESSION)
        begin
            if (w.sf > SESSION_MAX)
                nrc = NRC_SFNS;
            else if (w.pdu != PDU_SHORT)
                nrc = NRC_LEN;
            else if (w.busy)
                nrc = NRC_COND;
            else
                session_mode = w.sf[1:0];
        end
        else if (w.sid == SID_SECURITY)
            nrc = security_answer(w, plen, b2, b3);
        else
            return 1'b0;
        if (nrc != NRC_NONE)
        begin
            r.resp_len = LEN_NEG;
            r.b0 = NEG_SID;
            r.b1 = w.sid;
            r.b2 = nrc;
            r.b3 = '0;
        end
        else
        begin
            r.resp_len = plen;
            r.b0 = w.sid + POS_OFFSET;
            r.b1 = w.sf;
            r.b2 = b2;
            r.b3 = b3;
        end
        r.unlocked = sec_open;
        return 1'b1;
    endfunction

    function automatic void check_field(string label, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, label, want_v, got_v);
            mismatches++;
        end
    endfunction

    // a key that can never equal any seed OR 0x1234
    function automatic logic [15:0] safe_key();
        logic [15:0] k;
        k = 16'($urandom);
        while ((k & KEY_MASK) == KEY_MASK)
            k = 16'($urandom);
        return k;
    endfunction

    function automatic word_t diag_word(logic [7:0] s, logic [7:0] f, logic [15:0] k,
                                        logic [11:0] n, logic b);
        word_t w;
        w.is_tick = REQ_DIAG;
        w.sid = s;
        w.sf = f;
        w.key_hi = k[15:8];
        w.key_lo = k[7:0];
        w.pdu = n;
        w.busy = b;
        return w;
    endfunction

    function automatic word_t tick_word();
        word_t w;
        w = diag_word(8'($urandom), 8'($urandom), 16'($urandom), 12'($urandom),
                      1'($urandom));
        w.is_tick = REQ_TICK;
        return w;
    endfunction

    function automatic word_t spoil(word_t w);
        case ($urandom_range(0, 2))
            0: w.sf = 8'($urandom);
            1: w.pdu = 12'($urandom);
            default: w.busy = 1'b1;
        endcase
        return w;
    endfunction

    task automatic put(word_t w);
        pending_words.push_back(w);
        made++;
    endtask

    task automatic add_random();
        int pick;
        word_t w;
        logic [7:0] f;
        logic [11:0] n;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            put(tick_word());
        else if (pick < 65)
        begin
            // seed then key exchange, now and then with a broken field
            w = diag_word(SID_SECURITY, SF_SEED, safe_key(), PDU_SHORT, 1'b0);
            put(($urandom_range(0, 9) == 0) ? spoil(w) : w);
            w = diag_word(SID_SECURITY, SF_KEY, safe_key(), PDU_KEY, 1'b0);
            put(($urandom_range(0, 9) == 0) ? spoil(w) : w);
        end
        else if (pick < 80)
        begin
            f = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            n = ($urandom_range(0, 4) != 0) ? PDU_SHORT : 12'($urandom);
            put(diag_word(SID_SESSION, f, safe_key(), n, $urandom_range(0, 9) == 0));
        end
        else if (pick < 90)
        begin
            f = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
            case ($urandom_range(0, 2))
                0: n = PDU_SHORT;
                1: n = PDU_KEY;
                default: n = 12'($urandom);
            endcase
            put(diag_word(SID_SECURITY, f, safe_key(), n, 1'($urandom)));
        end
        else
            put(diag_word(8'($urandom), 8'($urandom), safe_key(), 12'($urandom),
                          1'($urandom)));
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SEED: seed_reg = val;
            CFG_LOCKOUT: lockout_reg = val;
            default: max_fail_reg = val[3:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || push || due_responses.size() != 0)
            @(negedge clk);
        // ticks and dropped services give no response, let the pipe settle
        repeat (8) @(posedge clk);
    endtask

    task automatic flush_lockout();
        if (lock_run)
        begin
            repeat (int'(lock_left) + 1) put(tick_word());
            drain();
        end
    endtask

    // sender: bursts with random gaps
    always @(negedge clk)
    begin : send_side
        if (!rst_n)
            push <= 1'b0;
        else if (!push || word_taken)
        begin
            word_taken = 1'b0;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    burst_left = 200;
                    gap_left = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pending_words.size() == 0)
                push <= 1'b0;
            else
            begin
                req_type <= pending_words[0].is_tick;
                sid <= pending_words[0].sid;
                sub_function <= pending_words[0].sf;
                key_high <= pending_words[0].key_hi;
                key_low <= pending_words[0].key_lo;
                pdu_length <= pending_words[0].pdu;
                loader_busy <= pending_words[0].busy;
                push <= 1'b1;
                burst_left--;
            end
        end
    end

    always @(posedge clk)
    begin : accept_side
        res_t answer;
        if (rst_n && push && !full)
        begin
            if (serve_word(pending_words[0], answer))
                due_responses.push_back(answer);
            pending_words.delete(0);
            word_taken = 1'b1;
        end
    end

    // receiver: stall pattern changes every so often
    always @(negedge clk)
    begin : pop_side
        logic go;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0: go = 1'b1;
            1: go = $urandom_range(0, 3) != 0;
            2: go = $urandom_range(0, 3) == 0;
            default: go = (stall_tick % 5) < 2;
        endcase
        pop <= rst_n && !hold_long && go;
    end

    always @(posedge clk)
    begin : check_side
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (due_responses.size() == 0)
            begin
                $display("%0t: response word with none expected, got %0h %0h %0h %0h len %0d",
                         $time, resp_byte0, resp_byte1, resp_byte2, resp_byte3, resp_len);
                mismatches++;
            end
            else
            begin
                want = due_responses.pop_front();
                check_field("resp_len", want.resp_len, resp_len);
                check_field("resp_byte0", want.b0, resp_byte0);
                check_field("resp_byte1", want.b1, resp_byte1);
                check_field("resp_byte2", want.b2, resp_byte2);
                check_field("resp_byte3", want.b3, resp_byte3);
                check_field("unlocked", want.unlocked, unlocked);
            end
        end
    end

    // one long receiver hold-off so the block backs up into full
    initial
    begin : hold_off
        wait (hold_arm);
        repeat (40) @(negedge clk);
        hold_long <= 1'b1;
        repeat (300) @(negedge clk);
        hold_long <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] sd;
        logic [15:0] lt;
        logic [3:0] mf;
        int start;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at register defaults
        put(tick_word());
        put(diag_word(8'h00, 8'h00, 16'h0000, 12'h000, 1'b0));
        put(diag_word(8'hFF, 8'hFF, 16'hFFFF, 12'hFFF, 1'b1));
        put(diag_word(SID_SESSION, SESSION_MAX + 8'd1, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SESSION, 8'hFF, 16'hFFFF, 12'hFFF, 1'b1));
        put(diag_word(SID_SESSION, 8'd1, 16'h0000, 12'd3, 1'b0));
        put(diag_word(SID_SESSION, 8'd2, 16'h0000, PDU_SHORT, 1'b1));
        put(diag_word(SID_SESSION, 8'd0, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SESSION, SESSION_MAX, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, 8'd0, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, 12'd0, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b1));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, 8'd3, 16'h0000, PDU_KEY, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, 16'h0000, PDU_KEY, 1'b1));
        // three wrong keys in a row run into the lockout
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, 16'h0000, PDU_KEY, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, 16'hFFFF, PDU_KEY, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, KEY_MASK, PDU_KEY, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(tick_word());
        drain();
        flush_lockout();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    sd = 16'hFFFF;
                    lt = 16'd0;
                    mf = 4'd1;
                end
                1:
                begin
                    sd = 16'h0000;
                    lt = 16'd5;
                    mf = 4'd15;
                end
                2:
                begin
                    sd = 16'($urandom);
                    lt = 16'd20;
                    mf = 4'd3;
                end
                3:
                begin
                    sd = 16'h0001;
                    lt = 16'd180;
                    mf = 4'd2;
                end
                6:
                begin
                    sd = 16'h8000;
                    lt = 16'd12;
                    mf = 4'd4;
                end
                default:
                begin
                    sd = 16'($urandom);
                    lt = 16'($urandom_range(0, 40));
                    mf = 4'($urandom_range(1, 15));
                end
            endcase
            write_reg(CFG_SEED, sd);
            write_reg(CFG_LOCKOUT, lt);
            write_reg(CFG_MAX_FAIL, 16'(mf));
            hold_arm = 1'b1;
            start = made;
            while (made - start < PHASE_WORDS)
                add_random();
            drain();
            if (lock_left > 16'd200)
                flush_lockout();
        end

        // finally the correct key, after which the level stays raised
        write_reg(CFG_SEED, 16'hA5C3);
        flush_lockout();
        put(diag_word(SID_SECURITY, SF_KEY, 16'h0000, 12'd3, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SECURITY, SF_KEY, seed_reg | KEY_MASK, PDU_KEY, 1'b0));
        put(diag_word(SID_SECURITY, SF_SEED, 16'h0000, PDU_SHORT, 1'b0));
        put(diag_word(SID_SESSION, SESSION_MAX, 16'h0000, PDU_SHORT, 1'b0));
        repeat (20) add_random();
        drain();

        if (due_responses.size() != 0)
            $display("%0t: %0d expected responses never arrived", $time, due_responses.size());
        if (mismatches == 0 && due_responses.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
